FILE: hw/rtl/id3_priv_timestamp_parser_defines.svh
// assertion helpers for the id3 timestamp parser checks
`ifndef ID3_PRIV_TIMESTAMP_PARSER_DEFINES_SVH
`define ID3_PRIV_TIMESTAMP_PARSER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define ID3PT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("id3pt check failed");

// next-cycle implication, sampled on clk, off during reset
`define ID3PT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("id3pt check failed");

`endif

FILE: hw/rtl/id3pt_pkg.sv
package id3pt_pkg;

    // default header length for tag and frame headers
    localparam int HEADER_BYTES_DEFAULT = 10;

    // private frame layout
    localparam int OWNER_LEN = 44;
    localparam int PRIV_SIZE = 53;

    // result status codes
    typedef enum logic [1:0] {
        STATUS_OK     = 2'd0,
        STATUS_NO_ID3 = 2'd1,
        STATUS_FAIL   = 2'd2
    } status_t;

    // parser phase, one-hot
    typedef enum logic [3:0] {
        PH_TAG   = 4'b0001,
        PH_FRAME = 4'b0010,
        PH_PRIV  = 4'b0100,
        PH_SKIP  = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       stream_end;
    } item_t;

    typedef struct packed {
        status_t     status;
        logic        timestamp_found;
        logic [63:0] timestamp;
        logic [7:0]  major_version;
        logic [7:0]  tag_flags;
    } result_t;

    // owner string of the timestamp frame
    localparam logic [7:0] OWNER_BYTES [0:OWNER_LEN-1] = '{
        8'h63, 8'h6f, 8'h6d, 8'h2e, 8'h61, 8'h70, 8'h70, 8'h6c, 8'h65, 8'h2e,
        8'h73, 8'h74, 8'h72, 8'h65, 8'h61, 8'h6d, 8'h69, 8'h6e, 8'h67, 8'h2e,
        8'h74, 8'h72, 8'h61, 8'h6e, 8'h73, 8'h70, 8'h6f, 8'h72, 8'h74,
        8'h53, 8'h74, 8'h72, 8'h65, 8'h61, 8'h6d,
        8'h54, 8'h69, 8'h6d, 8'h65, 8'h73, 8'h74, 8'h61, 8'h6d, 8'h70
    };

    function automatic logic [7:0] owner_byte(input logic [5:0] idx);
        logic [7:0] res;
        res = 8'h00;
        if (idx < 6'(OWNER_LEN))
        begin
            res = OWNER_BYTES[idx];
        end
        return res;
    endfunction

    // "ID3" tag magic
    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] res;
        unique case (idx)
            2'd0:    res = 8'h49;
            2'd1:    res = 8'h44;
            default: res = 8'h33;
        endcase
        return res;
    endfunction

    // "PRIV" frame id
    function automatic logic [7:0] priv_byte(input logic [1:0] idx);
        logic [7:0] res;
        unique case (idx)
            2'd0:    res = 8'h50;
            2'd1:    res = 8'h52;
            2'd2:    res = 8'h49;
            default: res = 8'h56;
        endcase
        return res;
    endfunction

endpackage

FILE: hw/rtl/id3_priv_timestamp_parser.sv
// id3 tag parser: one stream byte per cycle unless stalled, extracts the private timestamp frame
// a result is registered and shows in the cycle after the byte that ends a tag, header or stream
// throughput: one byte per cycle unless stalled; per-byte state update is one registered pass
// a result waiting under stall does not block input unless a second result is due
// reset (rst_n low, async) clears all parser state; the parser waits for a tag header
module id3_priv_timestamp_parser #(
    parameter int HEADER_BYTES = id3pt_pkg::HEADER_BYTES_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  id3pt_pkg::item_t   item,
    output logic               result_valid,
    input  logic               result_stall,
    output id3pt_pkg::result_t result
);
    import id3pt_pkg::*;

    localparam logic [5:0]  LastIdx   = 6'(HEADER_BYTES - 1);
    localparam logic [31:0] HdrLen    = 32'(HEADER_BYTES);
    localparam logic [33:0] HdrLen34  = 34'(HEADER_BYTES);
    localparam logic [5:0]  OwnerIdx  = 6'(OWNER_LEN);
    localparam logic [5:0]  PrivLast  = 6'(PRIV_SIZE - 1);
    localparam logic [31:0] PrivSize  = 32'(PRIV_SIZE);

    phase_t      phase_reg, phase_next;
    logic [5:0]  idx_reg, idx_next;
    logic [31:0] tag_rem_reg, tag_rem_next;
    logic [31:0] frame_rem_reg, frame_rem_next;
    logic        header_ok_reg, header_ok_next;
    logic        is_priv_reg, is_priv_next;
    logic        owner_match_reg, owner_match_next;
    logic [63:0] accum_reg, accum_next;
    logic [63:0] last_ts_reg, last_ts_next;
    logic        found_reg, found_next;
    logic [7:0]  version_reg, version_next;
    logic [7:0]  flags_reg, flags_next;

    logic        result_valid_reg, result_valid_next;
    result_t     result_reg, result_next;

    logic        accept;
    logic        emit;
    status_t     emit_status;
    logic        done;
    logic        done_more;
    logic [7:0]  b;
    logic [32:0] used;
    logic [33:0] used_more;

    // stall only when a second result is due behind a stalled one
    assign item_stall   = result_valid_reg && result_stall && emit;
    assign accept       = item_valid && !item_stall;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign b            = item.data_byte;

    // frame length against the remaining tag count
    assign used      = {1'b0, HdrLen} + {1'b0, frame_rem_reg};
    assign used_more = HdrLen34 + {1'b0, used};

    // per-byte parser step
    always_comb
    begin
        phase_next       = phase_reg;
        idx_next         = idx_reg;
        tag_rem_next     = tag_rem_reg;
        frame_rem_next   = frame_rem_reg;
        header_ok_next   = header_ok_reg;
        is_priv_next     = is_priv_reg;
        owner_match_next = owner_match_reg;
        accum_next       = accum_reg;
        last_ts_next     = last_ts_reg;
        found_next       = found_reg;
        version_next     = version_reg;
        flags_next       = flags_reg;
        emit             = 1'b0;
        emit_status      = STATUS_OK;
        done             = 1'b0;
        done_more        = 1'b0;

        if (item.stream_end)
        begin
            emit        = 1'b1;
            emit_status = STATUS_FAIL;
        end
        else
        begin
            unique case (phase_reg)
                PH_FRAME:
                begin
                    if (idx_reg < 6'd4)
                    begin
                        if (idx_reg == 6'd0)
                        begin
                            is_priv_next   = 1'b1;
                            frame_rem_next = 32'd0;
                        end
                        if (b != priv_byte(idx_reg[1:0]))
                        begin
                            is_priv_next = 1'b0;
                        end
                    end
                    else if (idx_reg < 6'd8)
                    begin
                        frame_rem_next = {frame_rem_reg[23:0], b};
                    end
                    if (idx_reg != LastIdx)
                    begin
                        idx_next = idx_reg + 6'd1;
                    end
                    else
                    begin
                        tag_rem_next = (used >= {1'b0, tag_rem_reg}) ? 32'd0
                                     : tag_rem_reg - used[31:0];
                        idx_next     = 6'd0;
                        if (is_priv_reg && frame_rem_reg == PrivSize)
                        begin
                            phase_next       = PH_PRIV;
                            owner_match_next = 1'b1;
                            accum_next       = 64'd0;
                        end
                        else if (frame_rem_reg == 32'd0)
                        begin
                            done      = 1'b1;
                            done_more = {2'b00, tag_rem_reg} > used_more;
                        end
                        else
                        begin
                            phase_next = PH_SKIP;
                        end
                    end
                end

                PH_SKIP:
                begin
                    if (frame_rem_reg != 32'd0)
                    begin
                        frame_rem_next = frame_rem_reg - 32'd1;
                    end
                    if (frame_rem_reg <= 32'd1)
                    begin
                        done      = 1'b1;
                        done_more = tag_rem_reg > HdrLen;
                    end
                end

                PH_PRIV:
                begin
                    if (idx_reg < OwnerIdx)
                    begin
                        if (b != owner_byte(idx_reg))
                        begin
                            owner_match_next = 1'b0;
                        end
                    end
                    else if (idx_reg == OwnerIdx)
                    begin
                        if (b != 8'h00)
                        begin
                            owner_match_next = 1'b0;
                        end
                    end
                    else
                    begin
                        accum_next = {accum_reg[55:0], b};
                    end
                    if (idx_reg >= PrivLast)
                    begin
                        if (owner_match_next)
                        begin
                            last_ts_next = accum_next;
                            found_next   = 1'b1;
                        end
                        done      = 1'b1;
                        done_more = tag_rem_reg > HdrLen;
                    end
                    else
                    begin
                        idx_next = idx_reg + 6'd1;
                    end
                end

                // tag header, also taken for codes that mean nothing
                default:
                begin
                    if (idx_reg == 6'd0)
                    begin
                        header_ok_next = 1'b1;
                        tag_rem_next   = 32'd0;
                        found_next     = 1'b0;
                    end
                    if (idx_reg < 6'd3)
                    begin
                        if (b != magic_byte(idx_reg[1:0]))
                        begin
                            header_ok_next = 1'b0;
                        end
                    end
                    else if (idx_reg == 6'd3)
                    begin
                        if (header_ok_reg)
                        begin
                            version_next = b;
                        end
                    end
                    else if (idx_reg == 6'd5)
                    begin
                        if (header_ok_reg)
                        begin
                            flags_next = b;
                        end
                    end
                    else if (idx_reg >= 6'd6 && idx_reg < 6'd10)
                    begin
                        tag_rem_next = {tag_rem_reg[24:0], 7'b0} | {24'b0, b};
                    end
                    phase_next = PH_TAG;
                    if (idx_reg != LastIdx)
                    begin
                        idx_next = idx_reg + 6'd1;
                    end
                    else
                    begin
                        idx_next = 6'd0;
                        if (!header_ok_next)
                        begin
                            emit        = 1'b1;
                            emit_status = STATUS_NO_ID3;
                        end
                        else
                        begin
                            done      = 1'b1;
                            done_more = tag_rem_next > HdrLen;
                        end
                    end
                end
            endcase
        end

        // frame loop test: next frame header or end of tag
        if (done)
        begin
            idx_next = 6'd0;
            if (done_more)
            begin
                phase_next = PH_FRAME;
            end
            else
            begin
                emit        = 1'b1;
                emit_status = STATUS_OK;
            end
        end

        if (emit)
        begin
            phase_next = PH_TAG;
            idx_next   = 6'd0;
        end
    end

    // result register contents
    always_comb
    begin
        result_next.status          = emit_status;
        result_next.timestamp_found = found_next;
        result_next.timestamp       = last_ts_next;
        result_next.major_version   = version_next;
        result_next.tag_flags       = flags_next;

        result_valid_next = result_valid_reg;
        if (accept && emit)
        begin
            result_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
    end

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_TAG;
            idx_reg          <= 6'd0;
            tag_rem_reg      <= 32'd0;
            frame_rem_reg    <= 32'd0;
            header_ok_reg    <= 1'b1;
            is_priv_reg      <= 1'b0;
            owner_match_reg  <= 1'b1;
            accum_reg        <= 64'd0;
            last_ts_reg      <= 64'd0;
            found_reg        <= 1'b0;
            version_reg      <= 8'd0;
            flags_reg        <= 8'd0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
            if (accept)
            begin
                phase_reg       <= phase_next;
                idx_reg         <= idx_next;
                tag_rem_reg     <= tag_rem_next;
                frame_rem_reg   <= frame_rem_next;
                header_ok_reg   <= header_ok_next;
                is_priv_reg     <= is_priv_next;
                owner_match_reg <= owner_match_next;
                accum_reg       <= accum_next;
                last_ts_reg     <= last_ts_next;
                found_reg       <= found_next;
                version_reg     <= version_next;
                flags_reg       <= flags_next;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            result_reg <= result_next;
        end
    end

endmodule

FILE: hw/rtl/id3pt_checker.sv
`include "id3_priv_timestamp_parser_defines.svh"

module id3pt_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               item_valid,
    input logic               item_stall,
    input id3pt_pkg::item_t   item,
    input logic               result_valid,
    input logic               result_stall,
    input id3pt_pkg::result_t result
);
    import id3pt_pkg::*;

    // a stalled result holds
    `ID3PT_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(result))

    // input only stalls behind a waiting result
    `ID3PT_ASSERT_NOW(a_stall_cause, item_stall, result_valid && result_stall)

    // end of stream reports failure in the next cycle
    `ID3PT_ASSERT_NEXT(a_end_fails, item_valid && !item_stall && item.stream_end, result_valid && result.status == STATUS_FAIL)

    // a rejected header never reports a timestamp
    `ID3PT_ASSERT_NOW(a_no_id3_clean, result_valid && result.status == STATUS_NO_ID3, !result.timestamp_found)

endmodule

bind id3_priv_timestamp_parser id3pt_checker u_checker (.*);
